@@ rtl/mss_pkg.sv @@
// shared constants, types and helpers for the motor speed step sequencer
// no dependencies; imported by the sequencer top level

package mss_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam int MAX_STEPS   = 16;
  localparam int TABLE_DEPTH = 16;
  localparam int STEP_LIMIT  = (MAX_STEPS < TABLE_DEPTH) ? MAX_STEPS : TABLE_DEPTH;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int POS_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ID_W      = 16;
  localparam int SPEED_W   = 14;
  localparam int REQ_W     = 16;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 8;
  localparam int ENTRY_W   = SPEED_W + TIME_W;

  localparam logic signed [REQ_W-1:0] SPEED_MIN = -16'sd6000;
  localparam logic signed [REQ_W-1:0] SPEED_MAX = 16'sd6000;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic [TIME_W-1:0]         dur;
  } step_entry_t;

  function automatic logic signed [SPEED_W-1:0] clamp_speed(
    input logic signed [REQ_W-1:0] req
  );
    logic signed [REQ_W-1:0] s;
    s = req;
    if (s < SPEED_MIN) s = SPEED_MIN;
    if (s > SPEED_MAX) s = SPEED_MAX;
    return s[SPEED_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] clamp_count(input logic [COUNT_W-1:0] cnt);
    logic [POS_W-1:0] res;
    if (int'(cnt) > STEP_LIMIT) res = POS_W'(STEP_LIMIT);
    else                        res = POS_W'(cnt);
    return res;
  endfunction

endpackage

@@ rtl/mss_ram.sv @@
// generic single-port-write, registered-read ram
// no dependencies

module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/motor_speed_step_sequencer.sv @@
// motor speed step sequencer top level: step table ram, state update stage, output register
// depends on mss_pkg and mss_ram

// Takes one item per clock cycle when the result side keeps up. A load writes its
// step straight into the step table; a start or tick reads the table when it is
// transferred and its state update is made in the update stage after that read; a
// status from a start or an expiring tick then goes through the output register to
// the out_ channel. The read address of a tick is forwarded from the update stage,
// so back-to-back ticks see each other's step advance. Reading a step slot that was
// never loaded gives an undefined speed and duration.
module motor_speed_step_sequencer
  import mss_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [ID_W-1:0]           in_seq_id,
  input  logic [SLOT_W-1:0]         in_step_slot,
  input  logic signed [REQ_W-1:0]   in_step_speed,
  input  logic [TIME_W-1:0]         in_step_time,
  input  logic [COUNT_W-1:0]        in_count_req,
  input  logic [TIME_W-1:0]         in_elapsed,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ID_W-1:0]           out_status_id,
  output logic signed [SPEED_W-1:0] out_drive_speed,
  output logic                      out_running
);

  // sequencer state
  logic [POS_W-1:0]  step_total_r, step_total_nxt;
  logic [POS_W-1:0]  step_pos_r, step_pos_nxt;
  logic [TIME_W-1:0] time_left_r, time_left_nxt;
  logic              is_active_r, is_active_nxt;
  logic [ID_W-1:0]   active_id_r, active_id_nxt;

  // update stage
  logic              s1_valid_r;
  logic [1:0]        s1_op_r;
  logic [ID_W-1:0]   s1_id_r;
  logic [POS_W-1:0]  s1_cnt_r;
  logic [TIME_W-1:0] s1_elapsed_r;

  // output register
  logic                      out_valid_r;
  logic [ID_W-1:0]           out_id_r;
  logic signed [SPEED_W-1:0] out_speed_r;
  logic                      out_run_r;

  logic                      accept;
  logic                      s1_go;
  logic                      s1_res;
  logic [ID_W-1:0]           res_id;
  logic signed [SPEED_W-1:0] res_speed;
  logic                      res_run;
  logic [SLOT_W-1:0]         rd_addr;
  logic [POS_W-1:0]          pos_inc;
  logic [ENTRY_W-1:0]        rd_word;
  step_entry_t               rd_entry;
  step_entry_t               wr_entry;

  assign rd_entry = step_entry_t'(rd_word);
  assign wr_entry = '{speed: clamp_speed(in_step_speed), dur: in_step_time};

  assign pos_inc = step_pos_r + POS_W'(1);

  // state update for the item in the update stage
  always_comb begin
    step_total_nxt = step_total_r;
    step_pos_nxt   = step_pos_r;
    time_left_nxt  = time_left_r;
    is_active_nxt  = is_active_r;
    active_id_nxt  = active_id_r;
    s1_res         = 1'b0;
    res_id         = active_id_r;
    res_speed      = '0;
    res_run        = 1'b0;
    if (s1_valid_r) begin
      case (s1_op_r)
        OP_START: begin
          s1_res         = 1'b1;
          active_id_nxt  = s1_id_r;
          step_total_nxt = s1_cnt_r;
          step_pos_nxt   = '0;
          res_id         = s1_id_r;
          if (s1_cnt_r != '0 && rd_entry.dur != '0) begin
            is_active_nxt = 1'b1;
            time_left_nxt = rd_entry.dur;
            res_speed     = rd_entry.speed;
            res_run       = 1'b1;
          end else begin
            is_active_nxt = 1'b0;
          end
        end
        OP_TICK: begin
          if (is_active_r && s1_id_r == active_id_r) begin
            if (s1_elapsed_r >= time_left_r) begin
              s1_res       = 1'b1;
              step_pos_nxt = pos_inc;
              if (pos_inc < step_total_r) begin
                time_left_nxt = rd_entry.dur;
                res_speed     = rd_entry.speed;
                res_run       = 1'b1;
              end else begin
                is_active_nxt = 1'b0;
              end
            end else begin
              time_left_nxt = time_left_r - s1_elapsed_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign s1_go    = s1_valid_r && (!s1_res || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign accept   = in_valid && !in_stall;

  // tick reads the next step, using the position after the stage ahead of it
  always_comb begin
    if (in_op == OP_TICK) rd_addr = SLOT_W'(step_pos_nxt + POS_W'(1));
    else                  rd_addr = '0;
  end

  mss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_step_ram (
    .clk     (clk),
    .wr_en   (accept && in_op == OP_LOAD),
    .wr_addr (in_step_slot),
    .wr_data (wr_entry),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_total_r <= '0;
      step_pos_r   <= '0;
      time_left_r  <= '0;
      is_active_r  <= 1'b0;
      active_id_r  <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (s1_go) begin
        step_total_r <= step_total_nxt;
        step_pos_r   <= step_pos_nxt;
        time_left_r  <= time_left_nxt;
        is_active_r  <= is_active_nxt;
        active_id_r  <= active_id_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go && s1_res) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r      <= in_op;
      s1_id_r      <= in_seq_id;
      s1_cnt_r     <= clamp_count(in_count_req);
      s1_elapsed_r <= in_elapsed;
    end
    if (s1_go && s1_res) begin
      out_id_r    <= res_id;
      out_speed_r <= res_speed;
      out_run_r   <= res_run;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status_id   = out_id_r;
  assign out_drive_speed = out_speed_r;
  assign out_running     = out_run_r;

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the motor speed step sequencer: directed step table and
// sequence cases, then random load/start/tick/spare traffic under varying idle and stall
// depends on mss_pkg and motor_speed_step_sequencer

module tb_top;
  import mss_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [1:0]              op;
    logic [ID_W-1:0]         seq_id;
    logic [SLOT_W-1:0]       slot;
    logic signed [REQ_W-1:0] speed;
    logic [TIME_W-1:0]       dur;
    logic [COUNT_W-1:0]      count;
    logic [TIME_W-1:0]       elapsed;
  } seq_cmd_t;

  typedef struct {
    logic [ID_W-1:0]           id;
    logic signed [SPEED_W-1:0] speed;
    logic                      run;
  } drive_status_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_op = OP_LOAD;
  logic [ID_W-1:0]           in_seq_id = '0;
  logic [SLOT_W-1:0]         in_step_slot = '0;
  logic signed [REQ_W-1:0]   in_step_speed = '0;
  logic [TIME_W-1:0]         in_step_time = '0;
  logic [COUNT_W-1:0]        in_count_req = '0;
  logic [TIME_W-1:0]         in_elapsed = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [ID_W-1:0]           out_status_id;
  logic signed [SPEED_W-1:0] out_drive_speed;
  logic                      out_running;

  logic hold_on = 1'b0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   fault_cnt = 0;

  // predicted sequencer state
  logic signed [SPEED_W-1:0] step_speed_mem [TABLE_DEPTH];
  logic [TIME_W-1:0]         step_dur_mem [TABLE_DEPTH];
  logic [POS_W-1:0]          seq_len = '0;
  logic [POS_W-1:0]          seq_pos = '0;
  logic [TIME_W-1:0]         dwell_left = '0;
  logic                      seq_running = 1'b0;
  logic [ID_W-1:0]           seq_owner = '0;

  drive_status_t status_due [$];

  motor_speed_step_sequencer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_seq_id       (in_seq_id),
    .in_step_slot    (in_step_slot),
    .in_step_speed   (in_step_speed),
    .in_step_time    (in_step_time),
    .in_count_req    (in_count_req),
    .in_elapsed      (in_elapsed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status_id   (out_status_id),
    .out_drive_speed (out_drive_speed),
    .out_running     (out_running)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
  end

  // status checker
  always @(posedge clk) begin
    drive_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        $error("unexpected status: id %0d speed %0d running %0d",
               out_status_id, out_drive_speed, out_running);
        fault_cnt++;
      end else begin
        want = status_due.pop_front();
        if (out_status_id !== want.id) begin
          $error("status_id: expected %0d, got %0d", want.id, out_status_id);
          fault_cnt++;
        end
        if (out_drive_speed !== want.speed) begin
          $error("drive_speed: expected %0d, got %0d", want.speed, out_drive_speed);
          fault_cnt++;
        end
        if (out_running !== want.run) begin
          $error("running: expected %0d, got %0d", want.run, out_running);
          fault_cnt++;
        end
      end
    end
  end

  task automatic enter_step();
    logic [SLOT_W-1:0] idx;
    idx = seq_pos[SLOT_W-1:0];
    dwell_left = step_dur_mem[idx];
    status_due.push_back('{seq_owner, step_speed_mem[idx], 1'b1});
  endtask

  task automatic halt_sequence();
    seq_running = 1'b0;
    status_due.push_back('{seq_owner, '0, 1'b0});
  endtask

  // update the predicted state for one accepted item and queue any status it gives
  task automatic advance_sequencer(input seq_cmd_t c);
    int req;
    int n;
    case (c.op)
      OP_LOAD: begin
        req = c.speed;
        if (req < SPEED_MIN) req = SPEED_MIN;
        if (req > SPEED_MAX) req = SPEED_MAX;
        step_speed_mem[c.slot] = SPEED_W'(req);
        step_dur_mem[c.slot]   = c.dur;
      end
      OP_START: begin
        n = c.count;
        if (n > STEP_LIMIT) n = STEP_LIMIT;
        seq_owner = c.seq_id;
        seq_len   = POS_W'(n);
        seq_pos   = '0;
        if (n > 0 && step_dur_mem[0] != 0) begin
          seq_running = 1'b1;
          enter_step();
        end else begin
          halt_sequence();
        end
      end
      OP_TICK: begin
        if (seq_running && c.seq_id == seq_owner) begin
          if (c.elapsed >= dwell_left) begin
            seq_pos++;
            if (seq_pos < seq_len) enter_step();
            else halt_sequence();
          end else begin
            dwell_left -= c.elapsed;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(input seq_cmd_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= c.op;
    in_seq_id     <= c.seq_id;
    in_step_slot  <= c.slot;
    in_step_speed <= c.speed;
    in_step_time  <= c.dur;
    in_count_req  <= c.count;
    in_elapsed    <= c.elapsed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_sequencer(c);
  endtask

  function automatic seq_cmd_t noise_cmd();
    seq_cmd_t c;
    c.op      = 2'($urandom_range(0, 3));
    c.seq_id  = 16'($urandom);
    c.slot    = 4'($urandom);
    c.speed   = 16'($urandom);
    c.dur     = $urandom;
    c.count   = 8'($urandom);
    c.elapsed = $urandom;
    return c;
  endfunction

  function automatic seq_cmd_t mk_load(input int slot, input int speed, input logic [31:0] dur);
    seq_cmd_t c;
    c       = noise_cmd();
    c.op    = OP_LOAD;
    c.slot  = SLOT_W'(slot);
    c.speed = REQ_W'(speed);
    c.dur   = dur;
    return c;
  endfunction

  function automatic seq_cmd_t mk_start(input logic [15:0] id, input logic [7:0] cnt);
    seq_cmd_t c;
    c        = noise_cmd();
    c.op     = OP_START;
    c.seq_id = id;
    c.count  = cnt;
    return c;
  endfunction

  function automatic seq_cmd_t mk_tick(input logic [15:0] id, input logic [31:0] el);
    seq_cmd_t c;
    c         = noise_cmd();
    c.op      = OP_TICK;
    c.seq_id  = id;
    c.elapsed = el;
    return c;
  endfunction

  function automatic seq_cmd_t mk_cmd_spare();
    seq_cmd_t c;
    c    = noise_cmd();
    c.op = OP_SPARE;
    return c;
  endfunction

  function automatic logic [TIME_W-1:0] pick_dur();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 85) return TIME_W'($urandom_range(1, 30));
    return $urandom;
  endfunction

  // mostly well-formed runs: starts, ticks aimed at the owner, occasional reloads
  function automatic seq_cmd_t pick_cmd();
    seq_cmd_t c;
    int r;
    c = noise_cmd();
    r = $urandom_range(0, 99);
    if (!seq_running && r >= 17 && $urandom_range(0, 2) == 0) r = 10;
    if (r < 8) begin
      c.op = OP_LOAD;
      if ($urandom_range(0, 1)) c.speed = REQ_W'(int'($urandom_range(0, 12000)) - 6000);
      c.dur = pick_dur();
    end else if (r < 14) begin
      c.op = OP_START;
      if ($urandom_range(0, 7) != 0) c.count = COUNT_W'($urandom_range(0, 18));
    end else if (r < 17) begin
      c.op = OP_SPARE;
    end else begin
      c.op = OP_TICK;
      if ($urandom_range(0, 9) != 0) c.seq_id = seq_owner;
      case ($urandom_range(0, 9))
        0, 1, 2: c.elapsed = dwell_left;
        3:       c.elapsed = dwell_left - 1;
        4:       c.elapsed = '0;
        5:       ;
        default: c.elapsed = TIME_W'($urandom_range(0, 24));
      endcase
    end
    return c;
  endfunction

  task automatic test_load_clamp();
    send_cmd(mk_load(0, -32768, 32'd3));
    send_cmd(mk_load(1, 32767, 32'hFFFF_FFFF));
    send_cmd(mk_load(2, -6001, 32'd0));
    send_cmd(mk_load(3, 6001, 32'd1));
    send_cmd(mk_load(4, -6000, 32'd2));
    send_cmd(mk_load(5, 6000, 32'd0));
    send_cmd(mk_load(15, -5999, 32'd7));
  endtask

  task automatic test_tick_walk();
    send_cmd(mk_start(16'hFFFF, 8'd255));          // count clamp
    send_cmd(mk_tick(16'h1234, 32'hFFFF_FFFF));     // stray id
    send_cmd(mk_tick(16'hFFFF, 32'd1));             // partial
    send_cmd(mk_tick(16'hFFFF, 32'd2));             // exact expiry
    send_cmd(mk_tick(16'hFFFF, 32'hFFFF_FFFF));     // into zero-duration step
    send_cmd(mk_tick(16'hFFFF, 32'd0));             // zero-duration step ends
    send_cmd(mk_cmd_spare());
    send_cmd(mk_tick(16'hFFFF, 32'd5));             // excess is dropped
  endtask

  task automatic test_restart_cases();
    send_cmd(mk_start(16'h0000, 8'd0));
    send_cmd(mk_tick(16'h0000, 32'd0));             // nothing active
    send_cmd(mk_load(0, 100, 32'd0));
    send_cmd(mk_start(16'd7, 8'd3));                // first step has no duration
    send_cmd(mk_load(0, 1234, 32'd1));
    send_cmd(mk_start(16'd7, 8'd3));
    send_cmd(mk_tick(16'd7, 32'd1));
    send_cmd(mk_load(2, -1, 32'd4));                // reloaded while running
    send_cmd(mk_tick(16'd7, 32'hFFFF_FFFF));
    send_cmd(mk_tick(16'd7, 32'd4));                // past the last step
    send_cmd(mk_start(16'd9, 8'd1));
    send_cmd(mk_tick(16'd9, 32'd1));
  endtask

  task automatic test_table_refill();
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      send_cmd(mk_load(s, int'($urandom_range(0, 65535)) - 32768, pick_dur()));
    end
  endtask

  task automatic test_random_traffic(input int n, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_cmd(pick_cmd());
  endtask

  // receiver holds off while items keep coming, so the block backs up
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    repeat (120) send_cmd(pick_cmd());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_clamp();
    test_tick_walk();
    test_restart_cases();
    test_table_refill();
    test_random_traffic(360, 0, 0);
    test_random_traffic(360, 79, 0);
    test_random_traffic(360, 0, 79);
    test_random_traffic(360, 25, 25);
    test_backpressure();
    in_valid  <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fault_cnt == 0 && status_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
